### sv/square_law_envelope_detector_core_macros.svh
// Assertion helpers shared by the detector modules.
// Define ASSERT_OFF to compile the checks out.
`ifndef SQUARE_LAW_ENVELOPE_DETECTOR_CORE_MACROS_SVH
`define SQUARE_LAW_ENVELOPE_DETECTOR_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// check masked while reset is active
`define SLED_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check that also holds through reset
`define SLED_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SLED_ASSERT(lbl, clk, rst_n, prop, msg)
`define SLED_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

### sv/sled_pkg.sv
package sled_pkg;

    // Field and datapath widths
    localparam int ENV_W       = 17;
    localparam int OUT_TDATA_W = ((ENV_W + 7) / 8) * 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int GAIN_W      = 30;
    localparam int COEF_W      = 32;
    localparam int MUL_W       = 33;
    localparam int PROD_W      = 2 * MUL_W;
    localparam int SQ_W        = 32;
    localparam int SUM_W       = SQ_W + 2;
    localparam int SUM_HALF    = SUM_W / 2;
    localparam int Y_W         = 48;
    localparam int Y_FRAC      = 16;
    localparam int ACC_W       = 64;
    localparam int TERM_W      = 80;
    localparam int ROOT_W      = 32;
    localparam int ROOT_STEPS  = ROOT_W / 2;
    localparam int ROOT_CNT_W  = $clog2(ROOT_STEPS);

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_FEEDFORWARD_GAIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_FIRST   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_SECOND  = 2'd2;

    // Coefficient reset values
    localparam logic [GAIN_W-1:0]        GAIN_RESET = 30'd42016;
    localparam logic signed [COEF_W-1:0] A1_RESET   = -32'sd2128384648;
    localparam logic signed [COEF_W-1:0] A2_RESET   = 32'sd1054827824;

    // Saturation limits
    localparam logic signed [ACC_W-1:0] ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [ACC_W-1:0] ACC_MIN = 64'sh8000_0000_0000_0000;
    localparam logic [Y_W-1:0]          Y_MAX   = 48'h7FFF_FFFF_FFFF;
    localparam logic [Y_W-1:0]          Y_MIN   = 48'h8000_0000_0000;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_SUM,
        ST_FF_LO,
        ST_FF_HI,
        ST_FB1_LO,
        ST_FB1_HI,
        ST_FB2_LO,
        ST_FB2_HI,
        ST_FB2_LAST,
        ST_FB2_SUB,
        ST_CLAMP,
        ST_ROOT,
        ST_DONE
    } state_t;

    // Operand pair for the shared multiplier
    typedef enum logic [2:0] {
        MUL_SQUARE,
        MUL_FF_LO,
        MUL_FF_HI,
        MUL_FB1_LO,
        MUL_FB1_HI,
        MUL_FB2_LO,
        MUL_FB2_HI
    } mul_sel_t;

    // Product accumulator operation
    typedef enum logic [1:0] {
        TERM_HOLD,
        TERM_LOAD,
        TERM_ADD_FF,
        TERM_ADD_FB
    } term_op_t;

    // Filter sum operation
    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_FF,
        ACC_SUB
    } acc_op_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic     load;
        mul_sel_t mul_sel;
        logic     sum_load;
        term_op_t term_op;
        acc_op_t  acc_op;
        logic     y_load;
        logic     root_step;
        logic     out_load;
    } cmd_t;

endpackage

### sv/sled_ctrl.sv
`include "square_law_envelope_detector_core_macros.svh"

module sled_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic          m_ready,
    output logic          m_valid,
    output sled_pkg::cmd_t cmd
);
    import sled_pkg::*;

    state_t                state_reg, state_next;
    logic [ROOT_CNT_W-1:0] root_cnt_reg, root_cnt_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  root_last;
    logic                  out_free;

    assign root_last = (root_cnt_reg == ROOT_CNT_W'(ROOT_STEPS - 1));
    assign out_free  = !out_valid_reg || m_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:     if (s_valid) state_next = ST_SQUARE;
            ST_SQUARE:   state_next = ST_SUM;
            ST_SUM:      state_next = ST_FF_LO;
            ST_FF_LO:    state_next = ST_FF_HI;
            ST_FF_HI:    state_next = ST_FB1_LO;
            ST_FB1_LO:   state_next = ST_FB1_HI;
            ST_FB1_HI:   state_next = ST_FB2_LO;
            ST_FB2_LO:   state_next = ST_FB2_HI;
            ST_FB2_HI:   state_next = ST_FB2_LAST;
            ST_FB2_LAST: state_next = ST_FB2_SUB;
            ST_FB2_SUB:  state_next = ST_CLAMP;
            ST_CLAMP:    state_next = ST_ROOT;
            ST_ROOT:     if (root_last) state_next = ST_DONE;
            ST_DONE:     if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Outputs and datapath commands
    always_comb
    begin
        s_ready       = 1'b0;
        cmd.load      = 1'b0;
        cmd.mul_sel   = MUL_SQUARE;
        cmd.sum_load  = 1'b0;
        cmd.term_op   = TERM_HOLD;
        cmd.acc_op    = ACC_HOLD;
        cmd.y_load    = 1'b0;
        cmd.root_step = 1'b0;
        cmd.out_load  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_SQUARE:   cmd.mul_sel = MUL_SQUARE;
            ST_SUM:      cmd.sum_load = 1'b1;
            ST_FF_LO:    cmd.mul_sel = MUL_FF_LO;
            ST_FF_HI:
            begin
                cmd.mul_sel = MUL_FF_HI;
                cmd.term_op = TERM_LOAD;
            end
            ST_FB1_LO:
            begin
                cmd.mul_sel = MUL_FB1_LO;
                cmd.term_op = TERM_ADD_FF;
            end
            ST_FB1_HI:
            begin
                cmd.mul_sel = MUL_FB1_HI;
                cmd.term_op = TERM_LOAD;
                cmd.acc_op  = ACC_FF;
            end
            ST_FB2_LO:
            begin
                cmd.mul_sel = MUL_FB2_LO;
                cmd.term_op = TERM_ADD_FB;
            end
            ST_FB2_HI:
            begin
                cmd.mul_sel = MUL_FB2_HI;
                cmd.term_op = TERM_LOAD;
                cmd.acc_op  = ACC_SUB;
            end
            ST_FB2_LAST: cmd.term_op = TERM_ADD_FB;
            ST_FB2_SUB:  cmd.acc_op = ACC_SUB;
            ST_CLAMP:    cmd.y_load = 1'b1;
            ST_ROOT:     cmd.root_step = 1'b1;
            ST_DONE:     cmd.out_load = out_free;
            default:     s_ready = 1'b0;
        endcase
    end

    // Root step count and output valid
    always_comb
    begin
        root_cnt_next = (state_reg == ST_ROOT) ? root_cnt_reg + 1'b1 : '0;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (m_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            root_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            root_cnt_reg  <= root_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid = out_valid_reg;

    `SLED_ASSERT(a_accept_starts_work, clk, rst_n, (s_valid && s_ready) |=> (state_reg == ST_SQUARE), "accepted item did not start the sequence")
    `SLED_ASSERT(a_no_result_overwrite, clk, rst_n, cmd.out_load |-> (!out_valid_reg || m_ready), "unread result overwritten")
    `SLED_ASSERT_ALWAYS(a_root_cnt_clear, clk, (state_reg != ST_ROOT) |-> (root_cnt_reg == '0), "root step count not clear outside root phase")

endmodule

### sv/sled_dp.sv
`include "square_law_envelope_detector_core_macros.svh"

module sled_dp
#(
    parameter int SAMPLE_WIDTH   = 16,
    parameter int COEF_FRAC_BITS = 30
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  sled_pkg::cmd_t                      cmd,
    input  logic [SAMPLE_WIDTH-1:0]             sample,
    input  logic                                record_start,
    input  logic                                cfg_we,
    input  logic [sled_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sled_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic [sled_pkg::ENV_W-1:0]          envelope,
    output logic                                clamped
);
    import sled_pkg::*;

    localparam int FF_SHIFT = COEF_FRAC_BITS - Y_FRAC;

    // Coefficients
    logic [GAIN_W-1:0]        b0_reg;
    logic signed [COEF_W-1:0] a1_reg, a2_reg;

    // Filter history
    logic [SQ_W-1:0] sdly1_reg, sdly2_reg;
    logic [Y_W-1:0]  fdly1_reg, fdly2_reg;

    // Working registers
    logic [SAMPLE_WIDTH-1:0]  mag_reg, mag_next;
    logic [SQ_W-1:0]          x0_reg, x0_next;
    logic [SUM_W-1:0]         sum_reg, sum_next;
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_reg;
    logic signed [TERM_W-1:0] term_reg, term_next, mul_ext;
    logic signed [ACC_W-1:0]  acc_reg, acc_next, fb_term, ff_sat;
    logic [ACC_W-1:0]         ff_shifted;
    logic signed [ACC_W:0]    acc_diff;
    logic                     y_over, y_under;
    logic [Y_W-1:0]           y_next;
    logic                     sat_reg, sat_next;

    // Root unit
    logic [ROOT_W-1:0] rem_reg, rem_next;
    logic [ROOT_W-1:0] res_reg, res_next;
    logic [ROOT_W-1:0] bit_reg, bit_next;
    logic [ROOT_W-1:0] root_in, root_trial;

    logic [ENV_W-1:0] envelope_reg;
    logic             clamped_reg;

    // Configuration writes and history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0_reg    <= GAIN_RESET;
            a1_reg    <= A1_RESET;
            a2_reg    <= A2_RESET;
            sdly1_reg <= '0;
            sdly2_reg <= '0;
            fdly1_reg <= '0;
            fdly2_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_FEEDFORWARD_GAIN: b0_reg <= cfg_data[GAIN_W-1:0];
                    CFG_FEEDBACK_FIRST:   a1_reg <= signed'(cfg_data[COEF_W-1:0]);
                    CFG_FEEDBACK_SECOND:  a2_reg <= signed'(cfg_data[COEF_W-1:0]);
                    default:              b0_reg <= b0_reg;
                endcase
            end
            if (cmd.load && record_start)
            begin
                sdly1_reg <= '0;
                sdly2_reg <= '0;
                fdly1_reg <= '0;
                fdly2_reg <= '0;
            end
            else if (cmd.y_load)
            begin
                sdly2_reg <= sdly1_reg;
                sdly1_reg <= x0_reg;
                fdly2_reg <= fdly1_reg;
                fdly1_reg <= y_next;
            end
        end
    end

    // Sample magnitude
    assign mag_next = sample[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(~sample + 1'b1) : sample;

    // Shared multiplier operand select
    always_comb
    begin
        case (cmd.mul_sel)
            MUL_SQUARE:
            begin
                mul_a = MUL_W'(mag_reg);
                mul_b = MUL_W'(mag_reg);
            end
            MUL_FF_LO:
            begin
                mul_a = MUL_W'(b0_reg);
                mul_b = MUL_W'(sum_reg[SUM_HALF-1:0]);
            end
            MUL_FF_HI:
            begin
                mul_a = MUL_W'(b0_reg);
                mul_b = MUL_W'(sum_reg[SUM_W-1:SUM_HALF]);
            end
            MUL_FB1_LO:
            begin
                mul_a = MUL_W'(a1_reg);
                mul_b = MUL_W'(fdly1_reg[Y_FRAC-1:0]);
            end
            MUL_FB1_HI:
            begin
                mul_a = MUL_W'(a1_reg);
                mul_b = MUL_W'(signed'(fdly1_reg[Y_W-1:Y_FRAC]));
            end
            MUL_FB2_LO:
            begin
                mul_a = MUL_W'(a2_reg);
                mul_b = MUL_W'(fdly2_reg[Y_FRAC-1:0]);
            end
            MUL_FB2_HI:
            begin
                mul_a = MUL_W'(a2_reg);
                mul_b = MUL_W'(signed'(fdly2_reg[Y_W-1:Y_FRAC]));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Doubled square with saturation, then the feedforward tap sum
    always_comb
    begin
        if (|mul_reg[PROD_W-1:SQ_W-1])
            x0_next = '1;
        else
            x0_next = {mul_reg[SQ_W-2:0], 1'b0};
        sum_next = SUM_W'(x0_next) + SUM_W'({sdly1_reg, 1'b0}) + SUM_W'(sdly2_reg);
    end

    // Product accumulation (low partial product first)
    assign mul_ext = TERM_W'(mul_reg);

    always_comb
    begin
        case (cmd.term_op)
            TERM_LOAD:   term_next = mul_ext;
            TERM_ADD_FF: term_next = term_reg + (mul_ext <<< SUM_HALF);
            TERM_ADD_FB: term_next = term_reg + (mul_ext <<< Y_FRAC);
            default:     term_next = term_reg;
        endcase
    end

    // Filter sum with 64-bit saturation
    assign ff_shifted = term_reg[ACC_W-1:0] >> FF_SHIFT;
    assign ff_sat     = ff_shifted[ACC_W-1] ? ACC_MAX : signed'(ff_shifted);
    assign fb_term    = ACC_W'(term_reg >>> COEF_FRAC_BITS);
    assign acc_diff   = {acc_reg[ACC_W-1], acc_reg} - {fb_term[ACC_W-1], fb_term};

    always_comb
    begin
        case (cmd.acc_op)
            ACC_FF:  acc_next = ff_sat;
            ACC_SUB:
            begin
                if (acc_diff[ACC_W] != acc_diff[ACC_W-1])
                    acc_next = acc_diff[ACC_W] ? ACC_MIN : ACC_MAX;
                else
                    acc_next = acc_diff[ACC_W-1:0];
            end
            default: acc_next = acc_reg;
        endcase
    end

    // Clamp to 48 bits and pick the root input
    always_comb
    begin
        y_over  = !acc_reg[ACC_W-1] && (|acc_reg[ACC_W-2:Y_W-1]);
        y_under = acc_reg[ACC_W-1] && !(&acc_reg[ACC_W-2:Y_W-1]);
        if (y_over)
            y_next = Y_MAX;
        else if (y_under)
            y_next = Y_MIN;
        else
            y_next = acc_reg[Y_W-1:0];
        sat_next = y_over || y_next[Y_W-1];
        root_in  = y_next[Y_W-1] ? '0 : y_next[Y_W-1:Y_FRAC];
    end

    // One result bit per root step
    assign root_trial = res_reg + bit_reg;

    always_comb
    begin
        rem_next = rem_reg;
        res_next = res_reg;
        bit_next = bit_reg;
        if (cmd.y_load)
        begin
            rem_next = root_in;
            res_next = '0;
            bit_next = ROOT_W'(1) << (ROOT_W - 2);
        end
        else if (cmd.root_step)
        begin
            if (rem_reg >= root_trial)
            begin
                rem_next = rem_reg - root_trial;
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        mul_reg  <= mul_a * mul_b;
        term_reg <= term_next;
        acc_reg  <= acc_next;
        rem_reg  <= rem_next;
        res_reg  <= res_next;
        bit_reg  <= bit_next;
        if (cmd.load)
            mag_reg <= mag_next;
        if (cmd.sum_load)
        begin
            x0_reg  <= x0_next;
            sum_reg <= sum_next;
        end
        if (cmd.y_load)
            sat_reg <= sat_next;
        if (cmd.out_load)
        begin
            envelope_reg <= {res_reg[ENV_W-2:0], 1'b0};
            clamped_reg  <= sat_reg;
        end
    end

    assign envelope = envelope_reg;
    assign clamped  = clamped_reg;

    `SLED_ASSERT(a_negative_flagged, clk, rst_n, $past(cmd.y_load) |-> (!fdly1_reg[Y_W-1] || sat_reg), "negative filter output without clamp flag")
    `SLED_ASSERT(a_root_bit_onehot, clk, rst_n, cmd.root_step |-> $onehot(bit_reg), "root trial bit lost")
    `SLED_ASSERT(a_root_fits, clk, rst_n, cmd.out_load |-> (res_reg[ROOT_W-1:ENV_W-1] == '0), "root result too wide")

endmodule

### sv/square_law_envelope_detector_core.sv
// Square-law envelope detector: each sample is squared and doubled, low-pass filtered
// by a second-order section (b0, 2*b0, b0 feedforward, a1/a2 feedback from the
// configuration registers, Q2.30 by default), kept with 16 fraction bits, clamped at
// zero and to 48 bits, and reported as twice the integer square root of its integer
// part, with a flag when the filter output was negative or saturated. A set tuser bit
// on an input marks the start of a new record and clears all filter history first.
// Each accepted item is worked through in sequence: seven partial products
// go one after another through a single shared 33 x 33 multiplier, the sums are
// saturated in a 64-bit accumulator, and the square root resolves one result bit per
// cycle. A new item is taken only once the last result has gone to the output register;
// a waiting result sits in the output register while the next item is accepted and
// processed.
// Configuration writes are taken at any time and belong in idle periods.
module square_law_envelope_detector_core
#(
    parameter int SAMPLE_WIDTH   = 16,
    parameter int COEF_FRAC_BITS = 30
)
(
    input  logic                                      clk,
    input  logic                                      rst_n,
    // input stream
    input  logic                                      s_axis_tvalid,
    output logic                                      s_axis_tready,
    input  logic [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,  // sample
    input  logic [0:0]                                s_axis_tuser,  // record_start
    // result stream
    output logic                                      m_axis_tvalid,
    input  logic                                      m_axis_tready,
    output logic [sled_pkg::OUT_TDATA_W-1:0]          m_axis_tdata,  // envelope
    output logic [0:0]                                m_axis_tuser,  // clamped
    // register writes
    input  logic                                      cfg_valid,
    output logic                                      cfg_ready,
    input  logic [sled_pkg::CFG_IDX_W-1:0]            cfg_index,
    input  logic [sled_pkg::CFG_DATA_W-1:0]           cfg_data
);
    import sled_pkg::*;

    cmd_t             cmd;
    logic [ENV_W-1:0] envelope;
    logic             clamped;

    assign cfg_ready = 1'b1;

    sled_ctrl u_ctrl
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .m_ready (m_axis_tready),
        .m_valid (m_axis_tvalid),
        .cmd     (cmd)
    );

    sled_dp
    #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    )
    u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sample       (s_axis_tdata[SAMPLE_WIDTH-1:0]),
        .record_start (s_axis_tuser[0]),
        .cfg_we       (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .envelope     (envelope),
        .clamped      (clamped)
    );

    // Result transfer payload
    assign m_axis_tdata = {{(OUT_TDATA_W - ENV_W){1'b0}}, envelope};
    assign m_axis_tuser = clamped;

endmodule
